[hdl/pts_pkg.sv]
// Shared types and constants of the periodic tick task scheduler.
`default_nettype none
package pts_pkg;

    localparam int DATA_W      = 32;
    localparam int TIDX_W      = 3;
    localparam int MASK_W      = 8;
    localparam int SERVE_LIMIT = 8;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_SERVE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_SERVE,
        S_RESP
    } t_state;

endpackage
`default_nettype wire

[hdl/pts_if.sv]
// Request and response channel interfaces of the scheduler.
`default_nettype none
interface pts_req_if;
    import pts_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [DATA_W-1:0] period;
    logic [DATA_W-1:0] initial_delay;

    modport source (output valid, cmd, period, initial_delay, input ready);
    modport sink   (input valid, cmd, period, initial_delay, output ready);
endinterface

interface pts_rsp_if;
    import pts_pkg::*;
    logic              valid;
    logic              ready;
    logic [TIDX_W-1:0] task_index;
    logic [MASK_W-1:0] ready_mask;
    logic [1:0]        status;
    logic              last;

    modport source (output valid, task_index, ready_mask, status, last, input ready);
    modport sink   (input valid, task_index, ready_mask, status, last, output ready);
endinterface
`default_nettype wire

[hdl/pts_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none
module pts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire                                      i_clk,
    input  wire                                      i_wr_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]                         i_wr_data,
    input  wire                                      i_rd_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

[hdl/periodic_tick_task_scheduler.sv]
// Periodic tick task scheduler: task table in RAM, walked per command.
//
// Channels: i_req carries one command per transfer (add, tick, serve) with
// period and initial_delay; o_rsp returns results with task_index,
// ready_mask, status and last. Command code 3 is taken and dropped.
// Add: one result. Tick: walks the active slots through the task RAM, one read
// issued per cycle, each slot written back in the cycle after its read, then
// one result. Serve: walks ready flags one slot per cycle (a ready slot waits
// while o_rsp stalls) up to the highest ready slot, one result per ready task
// (at most eight), last set on the final one; with nothing ready a single
// "none" result. One command is in work at a time; i_req.ready is high only idle.
// The response register holds a result while o_rsp stalls; the walk waits
// on it, nothing is dropped. Reset (synchronous, i_rst_n low) empties the
// table and clears all ready flags; RAM contents need no clearing since only
// slots below the active count are ever read.
`default_nettype none
module periodic_tick_task_scheduler #(
    parameter int MAX_TASKS = 8
) (
    input wire       i_clk,
    input wire       i_rst_n,
    pts_req_if.sink   i_req,
    pts_rsp_if.source o_rsp
);
    import pts_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int RAM_W = 2 * DATA_W;

    // control state
    t_state               r_state,   n_state;
    logic [CNT_W-1:0]     r_active,  n_active;
    logic [MAX_TASKS-1:0] r_ready,   n_ready;
    logic                 r_iss,     n_iss;      // tick: more reads to issue
    logic                 r_rd_vld,  n_rd_vld;   // tick: RAM data is back
    logic                 r_out_vld, n_out_vld;

    // working registers
    logic [IDX_W-1:0]     r_idx,     n_idx;
    logic [IDX_W-1:0]     r_rd_idx,  n_rd_idx;
    logic [2:0]           r_n,       n_n;        // results given in this serve
    logic [TIDX_W-1:0]    r_res_idx, n_res_idx;
    t_status              r_res_st,  n_res_st;

    // response register
    logic [TIDX_W-1:0]    r_out_idx,  n_out_idx;
    logic [MASK_W-1:0]    r_out_mask, n_out_mask;
    t_status              r_out_st,   n_out_st;
    logic                 r_out_last, n_out_last;

    // RAM port, entry = {period, counter}
    logic                 ram_wr_en, ram_rd_en;
    logic [IDX_W-1:0]     ram_wr_addr, ram_rd_addr;
    logic [RAM_W-1:0]     ram_wr_data, ram_rd_data;

    logic                 out_free;
    logic [DATA_W-1:0]    tick_per, tick_dec;
    logic [MAX_TASKS-1:0] clr_mask;
    logic                 serve_last;

    pts_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_TASKS)
    ) u_task_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign out_free    = !r_out_vld || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign tick_per = ram_rd_data[RAM_W-1:DATA_W];
    assign tick_dec = ram_rd_data[DATA_W-1:0] - 1'b1;

    // served slot's flag dropped; last when nothing ready above or limit hit
    always_comb begin
        clr_mask        = r_ready;
        clr_mask[r_idx] = 1'b0;
    end
    assign serve_last = (((r_ready >> r_idx) >> 1) == '0) ||
                        (r_n == 3'(SERVE_LIMIT - 1));

    always_comb begin
        n_state    = r_state;
        n_active   = r_active;
        n_ready    = r_ready;
        n_iss      = r_iss;
        n_rd_vld   = r_rd_vld;
        n_idx      = r_idx;
        n_rd_idx   = r_rd_idx;
        n_n        = r_n;
        n_res_idx  = r_res_idx;
        n_res_st   = r_res_st;
        n_out_vld  = r_out_vld && !o_rsp.ready;
        n_out_idx  = r_out_idx;
        n_out_mask = r_out_mask;
        n_out_st   = r_out_st;
        n_out_last = r_out_last;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_active[IDX_W-1:0];
        ram_wr_data = {i_req.period, i_req.initial_delay};
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_idx;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.cmd)
                        CMD_ADD: begin
                            n_state = S_RESP;
                            if (r_active >= CNT_W'(MAX_TASKS)) begin
                                n_res_idx = '0;
                                n_res_st  = ST_FULL;
                            end else begin
                                ram_wr_en = 1'b1;
                                n_ready[r_active[IDX_W-1:0]] = 1'b0;
                                n_active  = r_active + 1'b1;
                                n_res_idx = TIDX_W'(r_active);
                                n_res_st  = ST_OK;
                            end
                        end
                        CMD_TICK: begin
                            n_state  = S_TICK;
                            n_idx    = '0;
                            n_iss    = (r_active != '0);
                            n_rd_vld = 1'b0;
                        end
                        CMD_SERVE: begin
                            if (r_ready == '0) begin
                                n_state   = S_RESP;
                                n_res_idx = '0;
                                n_res_st  = ST_NONE;
                            end else begin
                                n_state = S_SERVE;
                                n_idx   = '0;
                                n_n     = '0;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_TICK: begin
                // read slot r_idx while writing back the slot read last cycle
                if (r_iss) begin
                    ram_rd_en = 1'b1;
                    n_rd_vld  = 1'b1;
                    n_rd_idx  = r_idx;
                    n_idx     = r_idx + 1'b1;
                    n_iss     = ((CNT_W+1)'(r_idx) + 1'b1) < (CNT_W+1)'(r_active);
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (r_rd_vld) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_rd_idx;
                    if (tick_dec == '0) begin
                        n_ready[r_rd_idx] = 1'b1;
                        ram_wr_data = {tick_per, tick_per};
                    end else begin
                        ram_wr_data = {tick_per, tick_dec};
                    end
                end
                if (!r_iss && !r_rd_vld) begin
                    n_state   = S_RESP;
                    n_res_idx = '0;
                    n_res_st  = ST_OK;
                end
            end

            S_SERVE: begin
                if (r_ready[r_idx]) begin
                    if (out_free) begin
                        n_out_vld  = 1'b1;
                        n_out_idx  = TIDX_W'(r_idx);
                        n_out_mask = MASK_W'(clr_mask);
                        n_out_st   = ST_OK;
                        n_out_last = serve_last;
                        n_ready    = clr_mask;
                        n_n        = r_n + 1'b1;
                        n_idx      = r_idx + 1'b1;
                        if (serve_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_RESP: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_idx  = r_res_idx;
                    n_out_mask = (r_res_st == ST_NONE) ? '0 : MASK_W'(r_ready);
                    n_out_st   = r_res_st;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= '0;
            r_ready   <= '0;
            r_iss     <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_ready   <= n_ready;
            r_iss     <= n_iss;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_rd_idx   <= n_rd_idx;
        r_n        <= n_n;
        r_res_idx  <= n_res_idx;
        r_res_st   <= n_res_st;
        r_out_idx  <= n_out_idx;
        r_out_mask <= n_out_mask;
        r_out_st   <= n_out_st;
        r_out_last <= n_out_last;
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.task_index = r_out_idx;
    assign o_rsp.ready_mask = r_out_mask;
    assign o_rsp.status     = r_out_st;
    assign o_rsp.last       = r_out_last;
endmodule
`default_nettype wire

[tb/tb_periodic_tick_task_scheduler.sv]
// Self-checking testbench for the periodic tick task scheduler.
`timescale 1ns / 100ps
module tb_periodic_tick_task_scheduler;
    import pts_pkg::*;

    // Table size of the instance under test; the predictor is built for it.
    localparam int TABLE_SLOTS = 8;
    // Command code 3 is outside t_cmd: the block takes it and drops it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Non-ignored random commands to send after the directed part.
    localparam int RANDOM_ITEMS = 200;
    // Settle time after the last result.
    localparam int SETTLE_CYCLES = 40;

    // One expected result, as the response channel carries it.
    typedef struct {
        logic [TIDX_W-1:0] task_index;
        logic [MASK_W-1:0] ready_mask;
        t_status           status;
        logic              last;
    } sched_result_t;

    logic clk = 1'b0;
    logic rst_n;

    pts_req_if req_ch ();
    pts_rsp_if rsp_ch ();

    periodic_tick_task_scheduler #(
        .MAX_TASKS(TABLE_SLOTS)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted task table. Ticks and serves touch only slots below task_count.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] slot_period [TABLE_SLOTS];
    logic [DATA_W-1:0] slot_count  [TABLE_SLOTS];
    logic              slot_ready  [TABLE_SLOTS];
    int                task_count;

    // Results the block still owes, oldest first.
    sched_result_t results_due[$];

    int  mismatches = 0;
    // Idle knobs: when clear, that side runs without gaps or stalls.
    bit  req_gaps_on = 1'b1;
    bit  rsp_stalls_on = 1'b1;

    // Ready mask over the low eight slots.
    function automatic logic [MASK_W-1:0] ready_bits();
        logic [MASK_W-1:0] m;
        m = '0;
        for (int i = 0; i < TABLE_SLOTS && i < MASK_W; i++)
            if (slot_ready[i])
                m[i] = 1'b1;
        return m;
    endfunction

    function automatic void owe_result(int idx, logic [MASK_W-1:0] mask, t_status st,
                                       logic last);
        sched_result_t r;
        r.task_index = idx[TIDX_W-1:0];
        r.ready_mask = mask;
        r.status     = st;
        r.last       = last;
        results_due.push_back(r);
    endfunction

    // Advance the predicted table by one accepted command and queue its results.
    function automatic void predict_schedule(logic [1:0] code, logic [DATA_W-1:0] per,
                                             logic [DATA_W-1:0] dly);
        int served;
        served = 0;
        case (code)
            CMD_ADD: begin
                if (task_count >= TABLE_SLOTS) begin
                    owe_result(0, ready_bits(), ST_FULL, 1'b1);
                end else begin
                    slot_period[task_count] = per;
                    slot_count[task_count]  = dly;
                    slot_ready[task_count]  = 1'b0;
                    task_count++;
                    owe_result(task_count - 1, ready_bits(), ST_OK, 1'b1);
                end
            end
            CMD_TICK: begin
                // Counters wrap modulo 2^32; a zero counter goes to all ones.
                for (int i = 0; i < task_count; i++) begin
                    slot_count[i] = slot_count[i] - 1;
                    if (slot_count[i] == '0) begin
                        slot_ready[i] = 1'b1;
                        slot_count[i] = slot_period[i];
                    end
                end
                owe_result(0, ready_bits(), ST_OK, 1'b1);
            end
            CMD_SERVE: begin
                for (int i = 0; i < task_count && served < SERVE_LIMIT; i++) begin
                    if (slot_ready[i]) begin
                        slot_ready[i] = 1'b0;
                        owe_result(i, ready_bits(), ST_OK, 1'b0);
                        served++;
                    end
                end
                if (served == 0)
                    owe_result(0, '0, ST_NONE, 1'b1);
                else
                    results_due[results_due.size() - 1].last = 1'b1;
            end
            default: begin
                // unknown code: no state change, no result
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side: one transfer per call. Fields change on the falling
    // edge; the transfer is seen at the rising edge with valid and ready.
    // valid stays high into the next call when no gap is drawn.
    // ------------------------------------------------------------------
    task automatic send_cmd(logic [1:0] code, logic [DATA_W-1:0] per,
                            logic [DATA_W-1:0] dly);
        int gap;
        gap = req_gaps_on ? $urandom_range(0, 6) : 0;
        repeat (gap) begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= code;
        req_ch.period        <= per;
        req_ch.initial_delay <= dly;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        predict_schedule(code, per, dly);
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Response side: checks each transfer against the oldest owed result,
    // then draws a stall before the next transfer.
    // ------------------------------------------------------------------
    initial begin : rsp_sink
        int            stall_left;
        sched_result_t want;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                stall_left = rsp_stalls_on ? $urandom_range(0, 6) : 0;
                if (results_due.size() == 0) begin
                    $error("unexpected result: task_index %0d ready_mask %02h status %0d",
                           rsp_ch.task_index, rsp_ch.ready_mask, rsp_ch.status);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (rsp_ch.task_index !== want.task_index) begin
                        $error("task_index: expected %0d, got %0d",
                               want.task_index, rsp_ch.task_index);
                        mismatches++;
                    end
                    if (rsp_ch.ready_mask !== want.ready_mask) begin
                        $error("ready_mask: expected %02h, got %02h",
                               want.ready_mask, rsp_ch.ready_mask);
                        mismatches++;
                    end
                    if (rsp_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty table: serve finds nothing, tick has nothing to count, and an
    // unknown code is swallowed without a result.
    task automatic test_empty_table();
        send_cmd(CMD_SERVE, $urandom(), $urandom());
        send_cmd(CMD_TICK, $urandom(), $urandom());
        send_cmd(CMD_UNUSED, $urandom(), $urandom());
        send_cmd(CMD_SERVE, $urandom(), $urandom());
        drain();
    endtask

    // Fill all slots. Slot 0 has a zero period (ready once, then wraps),
    // slot 1 a zero delay under the widest period (wraps, never ready here).
    // The rest get short periods so that serves return long result trains.
    task automatic test_fill_table();
        send_cmd(CMD_ADD, '0, 32'd1);
        send_cmd(CMD_ADD, '1, '0);
        for (int i = 2; i < TABLE_SLOTS; i++)
            send_cmd(CMD_ADD, $urandom_range(1, 6), $urandom_range(1, 4));
        send_cmd(CMD_TICK, $urandom(), $urandom());
        drain();
    endtask

    // Adds into a full table store nothing; field extremes go through here.
    task automatic test_full_table();
        send_cmd(CMD_ADD, '1, '1);
        send_cmd(CMD_ADD, '0, '0);
        send_cmd(CMD_ADD, $urandom(), $urandom());
        drain();
    endtask

    // Let several tasks expire, serve them all, serve an empty set, then tick and serve once more.
    task automatic test_expiry_and_serve();
        repeat (6) send_cmd(CMD_TICK, $urandom(), $urandom());
        send_cmd(CMD_SERVE, $urandom(), $urandom());
        send_cmd(CMD_SERVE, $urandom(), $urandom());
        send_cmd(CMD_TICK, $urandom(), $urandom());
        send_cmd(CMD_SERVE, $urandom(), $urandom());
        drain();
    endtask

    // Runs of ticks closed by a serve, with some full-table adds and unknown
    // codes mixed in. Idle behavior of both sides is reshuffled now and then,
    // including stretches with no gaps and no stalls at all.
    task automatic test_random_traffic();
        int sent;
        int reshuffle_at;
        int burst;
        int pick;
        sent = 0;
        reshuffle_at = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= reshuffle_at) begin
                req_gaps_on   = $urandom_range(0, 1);
                rsp_stalls_on = $urandom_range(0, 1);
                reshuffle_at  = sent + $urandom_range(20, 40);
            end
            burst = $urandom_range(1, 5);
            repeat (burst) begin
                send_cmd(CMD_TICK, $urandom(), $urandom());
                sent++;
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_cmd(CMD_SERVE, $urandom(), $urandom());
            end else if (pick < 9) begin
                send_cmd(CMD_ADD, $urandom(), $urandom());
            end else begin
                send_cmd(CMD_UNUSED, $urandom(), $urandom());
                send_cmd(CMD_SERVE, $urandom(), $urandom());
            end
            sent++;
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.cmd           = CMD_TICK;
        req_ch.period        = '0;
        req_ch.initial_delay = '0;
        task_count = 0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_period[i] = '0;
            slot_count[i]  = '0;
            slot_ready[i]  = 1'b0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_fill_table();
        test_full_table();
        test_expiry_and_serve();
        test_random_traffic();

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

[periodic_tick_task_scheduler.f]
hdl/pts_pkg.sv
hdl/pts_if.sv
hdl/pts_ram.sv
hdl/periodic_tick_task_scheduler.sv
tb/tb_periodic_tick_task_scheduler.sv
